// File: src/pfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged frame manager package
// Request kinds, result status codes, datapath selector codes and the
// command and status words exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package pfm_pkg;

	// Request kinds.
	localparam logic [2:0] KIND_CREATE    = 3'd0;
	localparam logic [2:0] KIND_TRANSLATE = 3'd1;
	localparam logic [2:0] KIND_READ      = 3'd2;
	localparam logic [2:0] KIND_WRITE     = 3'd3;
	localparam logic [2:0] KIND_PAGEIN    = 3'd4;
	localparam logic [2:0] KIND_FINISH    = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FAULT  = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;
	localparam logic [1:0] ST_NOSLOT = 2'd3;

	// Replacement policies.
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_POLICY = 2'd0;
	localparam logic [1:0] CFG_FCOUNT = 2'd1;
	localparam logic [1:0] CFG_PSHIFT = 2'd2;

	// Page table address sources.
	localparam logic [1:0] A_REQ     = 2'd0;
	localparam logic [1:0] A_TGT_CNT = 2'd1;
	localparam logic [1:0] A_SCAN    = 2'd2;
	localparam logic [1:0] A_BEST    = 2'd3;

	// Page table write data sources.
	localparam logic [2:0] W_ZERO   = 3'd0;
	localparam logic [2:0] W_ACCESS = 3'd1;
	localparam logic [2:0] W_VCLR   = 3'd2;
	localparam logic [2:0] W_LOAD   = 3'd3;
	localparam logic [2:0] W_FCLR   = 3'd4;

	// Result frame sources.
	localparam logic [1:0] F_NONE  = 2'd0;
	localparam logic [1:0] F_ENTRY = 2'd1;
	localparam logic [1:0] F_GOT   = 2'd2;

	typedef struct packed {
		logic       latch;
		logic       mem_re;
		logic       mem_we;
		logic [1:0] asel;
		logic [2:0] wsel;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       claim;
		logic       rel_slot;
		logic       set_busy;
		logic       clr_busy;
		logic       stamp_inc;
		logic       got_cnt;
		logic       got_best;
		logic       scan_start;
		logic       scan_step;
		logic       best_clr;
		logic       res_we;
		logic [1:0] res_status;
		logic [1:0] fsel;
		logic       res_newpid;
		logic       res_victim;
	} pfm_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       too_big;
		logic       req_valid;
		logic       slot_valid;
		logic       cnt_at_procs;
		logic       slot_free;
		logic       cnt_at_pages;
		logic       ent_present;
		logic       cnt_at_eff;
		logic       frame_free;
		logic       scan_last;
		logic       have_victim;
	} pfm_sts_t;

endpackage

// File: src/paged_frame_manager_lru_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged frame manager, top level
// Per-process page tables over a pool of physical frames with LRU or FIFO
// page replacement.
// ----------------------------------------------------------------------------
// One request is in flight at a time: a request is taken when start is high
// and busy is low, and its single result word appears for exactly one cycle
// with done high, which the receiver must take as it comes. Create searches
// the process slots one by one, then clears the page entries of the new
// process through the single page table port. Finish reads each page entry
// of the process and then writes it back. Page in with a free frame searches
// the frames one by one; without one it reads every page table entry once
// through the memory port. There is no clearing pass after reset; the block
// takes requests at once.
// ----------------------------------------------------------------------------
module paged_frame_manager_lru_fifo_top #(
	parameter int MAX_PROCS  = 16,
	parameter int MAX_PAGES  = 64,
	parameter int MAX_FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [3:0]  pid,
	input  logic [5:0]  page,
	input  logic [17:0] size_bytes,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  frame,
	output logic [3:0]  new_pid,
	output logic        victim_valid,
	output logic [3:0]  victim_pid,
	output logic [5:0]  victim_page,
	output logic        victim_dirty,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [6:0]  cfg_wdata
);
	import pfm_pkg::*;

	pfm_cmd_t cmd;
	pfm_sts_t sts;

	pfm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pfm_dpath #(
		.MAX_PROCS  (MAX_PROCS),
		.MAX_PAGES  (MAX_PAGES),
		.MAX_FRAMES (MAX_FRAMES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.kind         (kind),
		.pid          (pid),
		.page         (page),
		.size_bytes   (size_bytes),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.status       (status),
		.frame        (frame),
		.new_pid      (new_pid),
		.victim_valid (victim_valid),
		.victim_pid   (victim_pid),
		.victim_page  (victim_page),
		.victim_dirty (victim_dirty)
	);

	// A result word leaves only once the controller is back in idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word issued while a request is still in work");

	// A taken request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start work");

	// Each request yields one result word, never two in a row.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// The page table is never read and written in the same cycle.
	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mem_we && cmd.mem_re))
		else $error("page table read and write collide");

endmodule

// File: src/pfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged frame manager controller
// Sequences each request through decode, table sweeps and result capture.
// ----------------------------------------------------------------------------
module pfm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pfm_pkg::pfm_sts_t sts,
	output pfm_pkg::pfm_cmd_t cmd
);
	import pfm_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SLOT   = 4'd2;
	localparam logic [3:0] S_CLR    = 4'd3;
	localparam logic [3:0] S_ENTRY  = 4'd4;
	localparam logic [3:0] S_FREE   = 4'd5;
	localparam logic [3:0] S_VSCAN  = 4'd6;
	localparam logic [3:0] S_VDRAIN = 4'd7;
	localparam logic [3:0] S_VPICK  = 4'd8;
	localparam logic [3:0] S_LOAD   = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;
	localparam logic [3:0] S_FIN2   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign busy = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.kind)
					KIND_CREATE: begin
						if (sts.too_big) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_BAD;
							state_nxt      = S_IDLE;
						end else begin
							cmd.cnt_clr = 1'b1;
							state_nxt   = S_SLOT;
						end
					end
					KIND_TRANSLATE, KIND_READ, KIND_WRITE, KIND_PAGEIN: begin
						if (!sts.req_valid) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_BAD;
							state_nxt      = S_IDLE;
						end else begin
							cmd.mem_re = 1'b1;
							cmd.asel   = A_REQ;
							state_nxt  = S_ENTRY;
						end
					end
					KIND_FINISH: begin
						if (!sts.slot_valid) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_BAD;
							state_nxt      = S_IDLE;
						end else begin
							cmd.cnt_clr = 1'b1;
							state_nxt   = S_FIN;
						end
					end
					default: begin
						cmd.res_we     = 1'b1;
						cmd.res_status = ST_BAD;
						state_nxt      = S_IDLE;
					end
				endcase
			end
			// Search for the lowest unused process slot.
			S_SLOT: begin
				if (sts.cnt_at_procs) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_NOSLOT;
					state_nxt      = S_IDLE;
				end else if (sts.slot_free) begin
					cmd.claim   = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_nxt   = S_CLR;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			// Clear the page entries of the new process.
			S_CLR: begin
				if (sts.cnt_at_pages) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_newpid = 1'b1;
					state_nxt      = S_IDLE;
				end else begin
					cmd.mem_we  = 1'b1;
					cmd.asel    = A_TGT_CNT;
					cmd.wsel    = W_ZERO;
					cmd.cnt_inc = 1'b1;
				end
			end
			// The requested entry is on the read port.
			S_ENTRY: begin
				if (!sts.ent_present) begin
					if (sts.kind == KIND_PAGEIN) begin
						cmd.cnt_clr  = 1'b1;
						cmd.best_clr = 1'b1;
						state_nxt    = S_FREE;
					end else begin
						cmd.res_we     = 1'b1;
						cmd.res_status = ST_FAULT;
						state_nxt      = S_IDLE;
					end
				end else begin
					if (sts.kind == KIND_READ || sts.kind == KIND_WRITE) begin
						cmd.mem_we    = 1'b1;
						cmd.asel      = A_REQ;
						cmd.wsel      = W_ACCESS;
						cmd.stamp_inc = 1'b1;
					end
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_OK;
					cmd.fsel       = F_ENTRY;
					state_nxt      = S_IDLE;
				end
			end
			// Search for the lowest free frame.
			S_FREE: begin
				if (sts.cnt_at_eff) begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_VSCAN;
				end else if (sts.frame_free) begin
					cmd.got_cnt = 1'b1;
					state_nxt   = S_LOAD;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			// Read every page entry once; the datapath keeps the best key.
			S_VSCAN: begin
				cmd.mem_re    = 1'b1;
				cmd.asel      = A_SCAN;
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_VDRAIN;
				end
			end
			S_VDRAIN: begin
				state_nxt = S_VPICK;
			end
			S_VPICK: begin
				if (!sts.have_victim) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_BAD;
					state_nxt      = S_IDLE;
				end else begin
					cmd.mem_we   = 1'b1;
					cmd.asel     = A_BEST;
					cmd.wsel     = W_VCLR;
					cmd.got_best = 1'b1;
					state_nxt    = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.set_busy   = 1'b1;
				cmd.stamp_inc  = 1'b1;
				cmd.mem_we     = 1'b1;
				cmd.asel       = A_REQ;
				cmd.wsel       = W_LOAD;
				cmd.res_we     = 1'b1;
				cmd.res_status = ST_OK;
				cmd.fsel       = F_GOT;
				cmd.res_victim = 1'b1;
				state_nxt      = S_IDLE;
			end
			// Release the frames of a finishing process, one page per pass.
			S_FIN: begin
				if (sts.cnt_at_pages) begin
					cmd.rel_slot   = 1'b1;
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_OK;
					state_nxt      = S_IDLE;
				end else begin
					cmd.mem_re = 1'b1;
					cmd.asel   = A_TGT_CNT;
					state_nxt  = S_FIN2;
				end
			end
			S_FIN2: begin
				cmd.clr_busy = 1'b1;
				cmd.mem_we   = 1'b1;
				cmd.asel     = A_TGT_CNT;
				cmd.wsel     = W_FCLR;
				cmd.cnt_inc  = 1'b1;
				state_nxt    = S_FIN;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: src/pfm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged frame manager datapath
// Page table memory, process table, frame busy map, stamp counter, victim
// search and result registers, driven by the controller's command word.
// ----------------------------------------------------------------------------
module pfm_dpath #(
	parameter int MAX_PROCS  = 16,
	parameter int MAX_PAGES  = 64,
	parameter int MAX_FRAMES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [6:0]        cfg_wdata,
	input  logic [2:0]        kind,
	input  logic [3:0]        pid,
	input  logic [5:0]        page,
	input  logic [17:0]       size_bytes,
	input  pfm_pkg::pfm_cmd_t cmd,
	output pfm_pkg::pfm_sts_t sts,
	output logic              done,
	output logic [1:0]        status,
	output logic [5:0]        frame,
	output logic [3:0]        new_pid,
	output logic              victim_valid,
	output logic [3:0]        victim_pid,
	output logic [5:0]        victim_page,
	output logic              victim_dirty
);
	import pfm_pkg::*;

	localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int PGW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int PCW   = $clog2(MAX_PAGES + 1);
	localparam int DEPTH = MAX_PROCS * MAX_PAGES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int M1    = (MAX_PROCS > MAX_PAGES) ? MAX_PROCS : MAX_PAGES;
	localparam int M2    = (M1 > MAX_FRAMES) ? M1 : MAX_FRAMES;
	localparam int M3    = (M2 > 127) ? M2 : 127;
	localparam int CW    = $clog2(M3 + 1);

	typedef struct packed {
		logic [FW-1:0] frm;
		logic          present;
		logic          dirty;
		logic [31:0]   acc;
		logic [31:0]   load;
	} ent_t;

	function automatic logic [AW-1:0] mk_addr(input logic [PW-1:0] s,
	                                           input logic [PGW-1:0] p);
		mk_addr = AW'(AW'(s) * AW'(MAX_PAGES)) + AW'(p);
	endfunction

	function automatic logic [PGW-1:0] page_ext_idx(input logic [5:0] p);
		logic [CW-1:0] e;
		e = CW'(p);
		page_ext_idx = e[PGW-1:0];
	endfunction

	function automatic logic [PW-1:0] pid_ext_idx(input logic [3:0] p);
		logic [CW-1:0] e;
		e = CW'(p);
		pid_ext_idx = e[PW-1:0];
	endfunction

	function automatic logic [5:0] page_bits(input logic [CW-1:0] v);
		page_bits = v[5:0];
	endfunction

	function automatic logic [3:0] pid_bits(input logic [CW-1:0] v);
		pid_bits = v[3:0];
	endfunction

	// Configuration registers.
	logic        policy_q;
	logic [6:0]  fcount_q;
	logic [3:0]  pshift_q;

	// Latched request.
	logic [2:0]  kind_q;
	logic [3:0]  pid_q;
	logic [5:0]  page_q;
	logic [17:0] size_q;

	// Process table, frame map and stamp.
	logic [MAX_PROCS-1:0]  used_q;
	logic [PCW-1:0]        npages_q [MAX_PROCS];
	logic [MAX_FRAMES-1:0] fbusy_q;
	logic [31:0]           stamp_q;

	// Working registers.
	logic [CW-1:0]  cnt_q;
	logic [PW-1:0]  tgt_q;
	logic [FW-1:0]  got_q;
	logic [PW-1:0]  ss_q;
	logic [PGW-1:0] sp_q;
	logic           sv_s1;
	logic           sq_s1;
	logic [PW-1:0]  ssl_s1;
	logic [PGW-1:0] spl_s1;
	logic           have_q;
	logic [PW-1:0]  bs_q;
	logic [PGW-1:0] bp_q;
	logic [FW-1:0]  bf_q;
	logic           bd_q;
	logic [31:0]    bkey_q;
	logic [31:0]    bload_q;

	// Page table memory.
	ent_t           mem [DEPTH];
	ent_t           rd_s1;
	ent_t           wd;
	logic [AW-1:0]  addr;

	logic [CW-1:0]  pid_ext;
	logic [PW-1:0]  pid_idx;
	logic [PGW-1:0] page_idx;
	logic           pid_ok;
	logic           used_at_pid;
	logic [18:0]    psum;
	logic [18:0]    pcalc;
	logic [CW-1:0]  eff;
	logic           cand;
	logic [31:0]    key;
	logic           upd;
	logic [PW-1:0]  cnt_pidx;
	logic [PW-1:0]  in_pidx;

	assign pid_ext     = CW'(pid_q);
	assign pid_ok      = pid_ext < CW'(MAX_PROCS);
	assign pid_idx     = pid_ext[PW-1:0];
	assign page_idx    = page_ext_idx(page_q);
	assign used_at_pid = pid_ok ? used_q[pid_idx] : 1'b0;
	assign cnt_pidx    = cnt_q[PW-1:0];
	assign in_pidx     = pid_ext_idx(pid);

	// Page count of a new process: size rounded up to whole pages.
	assign psum  = {1'b0, size_q} + ((19'd1 << pshift_q) - 19'd1);
	assign pcalc = psum >> pshift_q;

	// Frames in use.
	assign eff = (CW'(fcount_q) < CW'(MAX_FRAMES)) ? CW'(fcount_q) : CW'(MAX_FRAMES);

	// Status toward the controller.
	always_comb begin
		sts.kind         = kind_q;
		sts.too_big      = pcalc > 19'(MAX_PAGES);
		sts.slot_valid   = used_at_pid;
		sts.req_valid    = used_at_pid && (CW'(page_q) < CW'(npages_q[pid_idx]));
		sts.cnt_at_procs = cnt_q == CW'(MAX_PROCS);
		sts.slot_free    = !used_q[cnt_pidx];
		sts.cnt_at_pages = cnt_q == CW'(npages_q[tgt_q]);
		sts.ent_present  = rd_s1.present;
		sts.cnt_at_eff   = cnt_q == eff;
		sts.frame_free   = !fbusy_q[cnt_q[FW-1:0]];
		sts.scan_last    = (CW'(ss_q) == CW'(MAX_PROCS - 1)) &&
		                   (CW'(sp_q) == CW'(MAX_PAGES - 1));
		sts.have_victim  = have_q;
	end

	// Page table address selection.
	always_comb begin
		case (cmd.asel)
			A_REQ:     addr = mk_addr(pid_idx, page_idx);
			A_TGT_CNT: addr = mk_addr(tgt_q, cnt_q[PGW-1:0]);
			A_SCAN:    addr = mk_addr(ss_q, sp_q);
			A_BEST:    addr = mk_addr(bs_q, bp_q);
			default:   addr = mk_addr(pid_idx, page_idx);
		endcase
	end

	// Page table write data selection.
	always_comb begin
		wd = '0;
		case (cmd.wsel)
			W_ZERO: begin
				wd = '0;
			end
			W_ACCESS: begin
				wd       = rd_s1;
				wd.acc   = stamp_q + 32'd1;
				wd.dirty = rd_s1.dirty | (kind_q == KIND_WRITE);
			end
			W_VCLR: begin
				wd      = '0;
				wd.load = bload_q;
			end
			W_LOAD: begin
				wd.frm     = got_q;
				wd.present = 1'b1;
				wd.dirty   = 1'b0;
				wd.acc     = stamp_q + 32'd1;
				wd.load    = stamp_q + 32'd1;
			end
			W_FCLR: begin
				wd         = rd_s1;
				wd.present = 1'b0;
			end
			default: begin
				wd = '0;
			end
		endcase
	end

	// Page table memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[addr] <= wd;
		end
		if (cmd.mem_re) begin
			rd_s1 <= mem[addr];
		end
	end

	// Victim candidate from the entry read on the previous scan step.
	assign cand = sv_s1 && sq_s1 && rd_s1.present && (CW'(rd_s1.frm) < eff);
	assign key  = (policy_q == POLICY_FIFO) ? rd_s1.load : rd_s1.acc;
	assign upd  = cand && (!have_q || key < bkey_q);

	// Configuration, process table, frame map, stamp and output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_LRU;
			fcount_q <= 7'd64;
			pshift_q <= 4'd6;
			used_q   <= '0;
			for (int i = 0; i < MAX_PROCS; i++) begin
				npages_q[i] <= '0;
			end
			fbusy_q  <= '0;
			stamp_q  <= '0;
			have_q   <= 1'b0;
			sv_s1    <= 1'b0;
			done     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_POLICY: policy_q <= cfg_wdata[0];
					CFG_FCOUNT: fcount_q <= cfg_wdata;
					CFG_PSHIFT: pshift_q <= cfg_wdata[3:0];
					default:    policy_q <= policy_q;
				endcase
			end
			if (cmd.claim) begin
				used_q[cnt_pidx]   <= 1'b1;
				npages_q[cnt_pidx] <= pcalc[PCW-1:0];
			end
			if (cmd.rel_slot) begin
				used_q[tgt_q]   <= 1'b0;
				npages_q[tgt_q] <= '0;
			end
			if (cmd.set_busy) begin
				fbusy_q[got_q] <= 1'b1;
			end
			if (cmd.clr_busy && rd_s1.present && (CW'(rd_s1.frm) < CW'(MAX_FRAMES))) begin
				fbusy_q[rd_s1.frm] <= 1'b0;
			end
			if (cmd.stamp_inc) begin
				stamp_q <= stamp_q + 32'd1;
			end
			if (cmd.best_clr) begin
				have_q <= 1'b0;
			end else if (upd) begin
				have_q <= 1'b1;
			end
			sv_s1 <= cmd.scan_step;
			done  <= cmd.res_we;
		end
	end

	// Request latch, counters, scan position and best candidate.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			pid_q  <= pid;
			page_q <= page;
			size_q <= size_bytes;
			tgt_q  <= in_pidx;
		end
		if (cmd.claim) begin
			tgt_q <= cnt_pidx;
		end
		if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.got_cnt) begin
			got_q <= cnt_q[FW-1:0];
		end else if (cmd.got_best) begin
			got_q <= bf_q;
		end
		if (cmd.scan_start) begin
			ss_q <= '0;
			sp_q <= '0;
		end else if (cmd.scan_step) begin
			ssl_s1 <= ss_q;
			spl_s1 <= sp_q;
			sq_s1  <= used_q[ss_q] && (CW'(sp_q) < CW'(npages_q[ss_q]));
			if (CW'(sp_q) == CW'(MAX_PAGES - 1)) begin
				sp_q <= '0;
				ss_q <= ss_q + PW'(1);
			end else begin
				sp_q <= sp_q + PGW'(1);
			end
		end
		if (upd) begin
			bs_q    <= ssl_s1;
			bp_q    <= spl_s1;
			bf_q    <= rd_s1.frm;
			bd_q    <= rd_s1.dirty;
			bkey_q  <= key;
			bload_q <= rd_s1.load;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			status <= cmd.res_status;
			case (cmd.fsel)
				F_ENTRY: frame <= page_bits(CW'(rd_s1.frm));
				F_GOT:   frame <= page_bits(CW'(got_q));
				default: frame <= '0;
			endcase
			new_pid      <= cmd.res_newpid ? pid_bits(CW'(tgt_q)) : 4'd0;
			victim_valid <= cmd.res_victim && have_q;
			victim_pid   <= (cmd.res_victim && have_q) ? pid_bits(CW'(bs_q)) : 4'd0;
			victim_page  <= (cmd.res_victim && have_q) ? page_bits(CW'(bp_q)) : 6'd0;
			victim_dirty <= cmd.res_victim && have_q && bd_q;
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged frame manager testbench
// A queue-fed driver sends requests to the block, with random idle bursts.
// A monitor predicts each accepted request against a cycle-free copy of the
// page tables and checks every result word field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import pfm_pkg::*;

	localparam int  NPROCS = 16;
	localparam int  NPAGES = 64;
	localparam int  NFRAMES = 64;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  pid;
		logic [5:0]  page;
		logic [17:0] size_bytes;
	} req_t;

	typedef struct {
		logic [1:0] status;
		logic [5:0] frame;
		logic [3:0] new_pid;
		logic       victim_valid;
		logic [3:0] victim_pid;
		logic [5:0] victim_page;
		logic       victim_dirty;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [3:0]  pid;
	logic [5:0]  page;
	logic [17:0] size_bytes;
	logic        done;
	logic [1:0]  status;
	logic [5:0]  frame;
	logic [3:0]  new_pid;
	logic        victim_valid;
	logic [3:0]  victim_pid;
	logic [5:0]  victim_page;
	logic        victim_dirty;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [6:0]  cfg_wdata;

	paged_frame_manager_lru_fifo_top dut (.*);

	// Shadow copy of the page tables and configuration.
	logic [5:0]  pt_frame [NPROCS][NPAGES];
	bit          pt_present [NPROCS][NPAGES];
	bit          pt_dirty [NPROCS][NPAGES];
	logic [31:0] pt_acc [NPROCS][NPAGES];
	logic [31:0] pt_load [NPROCS][NPAGES];
	bit          slot_used [NPROCS];
	int          slot_pages [NPROCS];
	bit          frame_taken [NFRAMES];
	logic [31:0] access_stamp;
	logic        cur_policy;
	logic [6:0]  cur_fcount;
	logic [3:0]  cur_pshift;

	req_t  pending_reqs[$];
	res_t  expected_results[$];
	int    error_count;
	bit    took;
	int    gap_left;
	bit    no_idle;
	longint cycles;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Work out the result of one request and update the shadow state.
	function automatic res_t compute_result(req_t r);
		res_t o;
		int   npg, nf, got, bp, bg;
		bit   found, have;
		logic [31:0] bkey, key;
		o = '{default: '0};
		o.status = ST_BAD;
		case (r.kind)
			KIND_CREATE: begin
				npg = (int'(r.size_bytes) + (1 << cur_pshift) - 1) >> cur_pshift;
				if (npg <= NPAGES) begin
					o.status = ST_NOSLOT;
					for (int i = 0; i < NPROCS; i++) begin
						if (!slot_used[i]) begin
							slot_used[i] = 1;
							slot_pages[i] = npg;
							for (int j = 0; j < npg; j++) begin
								pt_frame[i][j] = '0;
								pt_present[i][j] = 0;
								pt_dirty[i][j] = 0;
								pt_acc[i][j] = '0;
								pt_load[i][j] = '0;
							end
							o.status = ST_OK;
							o.new_pid = i[3:0];
							break;
						end
					end
				end
			end
			KIND_TRANSLATE, KIND_READ, KIND_WRITE: begin
				if (slot_used[r.pid] && r.page < slot_pages[r.pid]) begin
					if (!pt_present[r.pid][r.page]) begin
						o.status = ST_FAULT;
					end else begin
						o.status = ST_OK;
						o.frame = pt_frame[r.pid][r.page];
						if (r.kind != KIND_TRANSLATE) begin
							access_stamp++;
							pt_acc[r.pid][r.page] = access_stamp;
							if (r.kind == KIND_WRITE) pt_dirty[r.pid][r.page] = 1;
						end
					end
				end
			end
			KIND_PAGEIN: begin
				if (slot_used[r.pid] && r.page < slot_pages[r.pid]) begin
					if (pt_present[r.pid][r.page]) begin
						o.status = ST_OK;
						o.frame = pt_frame[r.pid][r.page];
					end else begin
						nf = (cur_fcount < NFRAMES) ? int'(cur_fcount) : NFRAMES;
						found = 0;
						got = 0;
						for (int i = 0; i < nf; i++) begin
							if (!frame_taken[i]) begin
								found = 1;
								got = i;
								break;
							end
						end
						// No free frame: the oldest stamp loses its frame, first on a tie.
						if (!found) begin
							have = 0;
							bp = 0;
							bg = 0;
							bkey = '0;
							for (int i = 0; i < NPROCS; i++) begin
								if (!slot_used[i]) continue;
								for (int j = 0; j < slot_pages[i]; j++) begin
									if (!pt_present[i][j] || pt_frame[i][j] >= nf) continue;
									key = (cur_policy == POLICY_FIFO) ? pt_load[i][j] : pt_acc[i][j];
									if (!have || key < bkey) begin
										have = 1;
										bp = i;
										bg = j;
										bkey = key;
									end
								end
							end
							if (have) begin
								found = 1;
								got = int'(pt_frame[bp][bg]);
								o.victim_valid = 1'b1;
								o.victim_pid = bp[3:0];
								o.victim_page = bg[5:0];
								o.victim_dirty = pt_dirty[bp][bg];
								pt_present[bp][bg] = 0;
								pt_dirty[bp][bg] = 0;
								pt_frame[bp][bg] = '0;
								pt_acc[bp][bg] = '0;
							end
						end
						if (found) begin
							frame_taken[got] = 1;
							access_stamp++;
							pt_frame[r.pid][r.page] = got[5:0];
							pt_present[r.pid][r.page] = 1;
							pt_dirty[r.pid][r.page] = 0;
							pt_acc[r.pid][r.page] = access_stamp;
							pt_load[r.pid][r.page] = access_stamp;
							o.status = ST_OK;
							o.frame = got[5:0];
						end
					end
				end
			end
			KIND_FINISH: begin
				if (slot_used[r.pid]) begin
					for (int j = 0; j < slot_pages[r.pid]; j++) begin
						if (pt_present[r.pid][j]) frame_taken[pt_frame[r.pid][j]] = 0;
						pt_present[r.pid][j] = 0;
					end
					slot_used[r.pid] = 0;
					slot_pages[r.pid] = 0;
					o.status = ST_OK;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Driver: one word per handshake, with random idle bursts between words.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (start && !took) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_reqs.size() != 0) begin
			req_t r;
			r = pending_reqs.pop_front();
			start <= 1'b1;
			kind <= r.kind;
			pid <= r.pid;
			page <= r.page;
			size_bytes <= r.size_bytes;
			if (!no_idle && $urandom_range(0, 3) == 0) gap_left <= int'($urandom_range(1, 15));
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: check result words, then predict newly accepted requests.
	always @(posedge clk) begin
		res_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
		took <= start && !busy;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected");
				error_count++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					error_count++;
				end
				if (frame !== e.frame) begin
					$error("frame expected %0d actual %0d", e.frame, frame);
					error_count++;
				end
				if (new_pid !== e.new_pid) begin
					$error("new_pid expected %0d actual %0d", e.new_pid, new_pid);
					error_count++;
				end
				if (victim_valid !== e.victim_valid) begin
					$error("victim_valid expected %0d actual %0d", e.victim_valid, victim_valid);
					error_count++;
				end
				if (victim_pid !== e.victim_pid) begin
					$error("victim_pid expected %0d actual %0d", e.victim_pid, victim_pid);
					error_count++;
				end
				if (victim_page !== e.victim_page) begin
					$error("victim_page expected %0d actual %0d", e.victim_page, victim_page);
					error_count++;
				end
				if (victim_dirty !== e.victim_dirty) begin
					$error("victim_dirty expected %0d actual %0d", e.victim_dirty, victim_dirty);
					error_count++;
				end
			end
		end
		if (arst_n && start && !busy)
			expected_results.push_back(compute_result('{kind, pid, page, size_bytes}));
	end

	function automatic req_t mk(logic [2:0] k, int p, int pg, int sz);
		req_t r;
		r.kind = k;
		r.pid = p[3:0];
		r.page = pg[5:0];
		r.size_bytes = sz[17:0];
		return r;
	endfunction

	// Random request, mostly aimed at a few live slots and low pages.
	function automatic req_t random_req();
		req_t r;
		int   sel;
		sel = int'($urandom_range(0, 99));
		r.pid = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
		                                      4'($urandom_range(0, 3));
		r.page = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63)) :
		                                       6'($urandom_range(0, 7));
		r.size_bytes = 18'($urandom_range(0, 262143));
		if (sel < 14) begin
			r.kind = KIND_CREATE;
			if ($urandom_range(0, 5) != 0)
				r.size_bytes = 18'(($urandom_range(0, 10) << cur_pshift) -
				                   $urandom_range(0, 3));
		end
		else if (sel < 22) r.kind = KIND_FINISH;
		else if (sel < 50) r.kind = KIND_PAGEIN;
		else if (sel < 70) r.kind = KIND_READ;
		else if (sel < 85) r.kind = KIND_WRITE;
		else if (sel < 97) r.kind = KIND_TRANSLATE;
		else r.kind = 3'($urandom_range(6, 7));
		return r;
	endfunction

	// Wait until every word is accepted, every result is back and the block is idle.
	task automatic drain();
		@(posedge clk);
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_POLICY: cur_policy = val[0];
			CFG_FCOUNT: cur_fcount = val;
			default:    cur_pshift = val[3:0];
		endcase
	endtask

	task automatic set_config(logic pol, logic [6:0] fc, logic [3:0] sh);
		write_reg(CFG_POLICY, {6'd0, pol});
		write_reg(CFG_FCOUNT, fc);
		write_reg(CFG_PSHIFT, {3'd0, sh});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	typedef struct {
		logic       pol;
		logic [6:0] fc;
		logic [3:0] sh;
	} cfg_t;

	initial begin
		cfg_t plan[6];
		plan[0] = '{POLICY_LRU, 7'd4, 4'd6};
		plan[1] = '{POLICY_FIFO, 7'd4, 4'd5};
		plan[2] = '{POLICY_LRU, 7'd1, 4'd4};
		plan[3] = '{POLICY_FIFO, 7'd64, 4'd12};
		plan[4] = '{POLICY_FIFO, 7'd2, 4'd4};
		plan[5] = '{POLICY_LRU, 7'd8, 4'd7};

		arst_n = 1'b0;
		kind = '0;
		pid = '0;
		page = '0;
		size_bytes = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		took = 1'b0;
		no_idle = 1'b0;
		cycles = 0;
		error_count = 0;
		access_stamp = '0;
		cur_policy = POLICY_LRU;
		cur_fcount = 7'd64;
		cur_pshift = 4'd6;
		foreach (slot_used[i]) begin
			slot_used[i] = 0;
			slot_pages[i] = 0;
		end
		foreach (frame_taken[i]) frame_taken[i] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset settings: faults, residency, bad requests.
		pending_reqs.push_back(mk(KIND_CREATE, 0, 0, 0));
		pending_reqs.push_back(mk(KIND_CREATE, 0, 0, 100));
		pending_reqs.push_back(mk(KIND_TRANSLATE, 1, 0, 0));
		pending_reqs.push_back(mk(KIND_READ, 1, 0, 0));
		pending_reqs.push_back(mk(KIND_PAGEIN, 1, 0, 0));
		pending_reqs.push_back(mk(KIND_PAGEIN, 1, 0, 0));
		pending_reqs.push_back(mk(KIND_READ, 1, 0, 0));
		pending_reqs.push_back(mk(KIND_WRITE, 1, 1, 0));
		pending_reqs.push_back(mk(KIND_PAGEIN, 1, 1, 0));
		pending_reqs.push_back(mk(KIND_WRITE, 1, 1, 0));
		pending_reqs.push_back(mk(KIND_TRANSLATE, 1, 1, 0));
		pending_reqs.push_back(mk(KIND_TRANSLATE, 1, 2, 0));
		pending_reqs.push_back(mk(KIND_TRANSLATE, 15, 63, 0));
		pending_reqs.push_back(mk(3'd6, 0, 0, 0));
		pending_reqs.push_back(mk(3'd7, 15, 63, 262143));
		pending_reqs.push_back(mk(KIND_FINISH, 0, 0, 0));
		pending_reqs.push_back(mk(KIND_FINISH, 0, 0, 0));
		pending_reqs.push_back(mk(KIND_CREATE, 0, 0, 262143));
		pending_reqs.push_back(mk(KIND_FINISH, 15, 0, 0));
		pending_reqs.push_back(mk(KIND_FINISH, 1, 0, 0));
		// The sender holds off here until every result has come back.
		drain();

		// Largest process on a single frame: dirty and clean evictions.
		set_config(POLICY_FIFO, 7'd1, 4'd12);
		pending_reqs.push_back(mk(KIND_CREATE, 0, 0, 262143));
		pending_reqs.push_back(mk(KIND_PAGEIN, 0, 63, 0));
		pending_reqs.push_back(mk(KIND_WRITE, 0, 63, 0));
		pending_reqs.push_back(mk(KIND_PAGEIN, 0, 0, 0));
		pending_reqs.push_back(mk(KIND_PAGEIN, 0, 63, 0));
		for (int i = 0; i < 16; i++) pending_reqs.push_back(mk(KIND_CREATE, 0, 0, 0));
		for (int i = 0; i < 16; i++) pending_reqs.push_back(mk(KIND_FINISH, i, 0, 0));
		drain();

		// Random phases across several settings; no idling in the last one.
		foreach (plan[p]) begin
			set_config(plan[p].pol, plan[p].fc, plan[p].sh);
			no_idle = (p == 5);
			for (int i = 0; i < 90; i++) pending_reqs.push_back(random_req());
			drain();
		end

		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
